@@ hw/rtl/piq_pkg.sv @@
// Shared types, field layout and command/status bundles for the positional insert queue.
package piq_pkg;

	// Operation carried by each input item
	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_SEARCH = 2'd3
	} action_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_POS   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Fixed field widths of the stream payloads
	localparam int ACT_W    = 2;
	localparam int POS_W    = 5;
	localparam int IO_W     = 16;
	localparam int STATUS_W = 2;
	localparam int ECNT_W   = 5;
	localparam int TDATA_W  = 40;

	// Input item layout
	localparam int IN_ACT_LSB = 0;
	localparam int IN_POS_LSB = IN_ACT_LSB + ACT_W;
	localparam int IN_X_LSB   = IN_POS_LSB + POS_W;
	localparam int IN_Y_LSB   = IN_X_LSB + IO_W;

	// Result item layout
	localparam int OUT_STATUS_LSB = 0;
	localparam int OUT_FOUND_LSB  = OUT_STATUS_LSB + STATUS_W;
	localparam int OUT_RX_LSB     = OUT_FOUND_LSB + 1;
	localparam int OUT_RY_LSB     = OUT_RX_LSB + IO_W;
	localparam int OUT_CNT_LSB    = OUT_RY_LSB + IO_W;

	// Controller to datapath commands
	typedef struct packed {
		logic    accept;
		logic    set_err;
		status_t err_code;
		logic    sh_rd;
		logic    sh_wr;
		logic    put;
		logic    rem_rd;
		logic    rem_fin;
		logic    srch_step;
		logic    set_found;
		logic    load_out;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		action_t action;
		logic    pos_bad;
		logic    full;
		logic    empty;
		logic    shift_more;
		logic    srch_hit;
		logic    srch_done;
		logic    out_free;
	} sts_t;

endpackage

@@ hw/rtl/piq_datapath.sv @@
// Entry memory, count and head pointer, walk index, result and output registers.
module piq_datapath #(
	parameter int DEPTH       = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [piq_pkg::TDATA_W-1:0]   s_tdata,
	input  logic                          m_tready,
	input  piq_pkg::cmd_t                 cmd,
	output piq_pkg::sts_t                 sts,
	output logic                          m_tvalid,
	output logic [piq_pkg::TDATA_W-1:0]   m_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = 2 * COORD_WIDTH;
	localparam int XW = CW + piq_pkg::POS_W;

	// Control state
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] idx_q;
	logic          rvalid_s1;
	logic          m_tvalid_q;

	// Payload state
	logic [EW-1:0]                  mem [DEPTH];
	logic [EW-1:0]                  rdata_q;
	logic [CW-1:0]                  pos_q;
	logic [COORD_WIDTH-1:0]         x_q;
	logic [COORD_WIDTH-1:0]         y_q;
	piq_pkg::status_t               res_status_q;
	logic                           res_found_q;
	logic [piq_pkg::IO_W-1:0]       res_rx_q;
	logic [piq_pkg::IO_W-1:0]       res_ry_q;
	logic [piq_pkg::TDATA_W-1:0]    m_tdata_q;

	// Unpacked input item
	piq_pkg::action_t               in_action;
	logic [piq_pkg::POS_W-1:0]      in_pos;
	logic [piq_pkg::IO_W-1:0]       in_x;
	logic [piq_pkg::IO_W-1:0]       in_y;
	logic [31:0]                    x_ext;
	logic [31:0]                    y_ext;
	logic [XW-1:0]                  pos_ext;
	logic [XW-1:0]                  cnt_ext;

	// Memory port controls
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [EW-1:0]                  wr_data;
	logic                           srch_issue;
	logic [31:0]                    rx_ext;
	logic [31:0]                    ry_ext;

	// Logical slot to physical address in the circular buffer
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
		logic [CW:0] s;
		s = (CW + 1)'(head) + (CW + 1)'(l);
		if (s >= (CW + 1)'(DEPTH)) begin
			s = s - (CW + 1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// Input field decode and coordinate sizing
	assign in_action = piq_pkg::action_t'(s_tdata[piq_pkg::IN_ACT_LSB +: piq_pkg::ACT_W]);
	assign in_pos    = s_tdata[piq_pkg::IN_POS_LSB +: piq_pkg::POS_W];
	assign in_x      = s_tdata[piq_pkg::IN_X_LSB +: piq_pkg::IO_W];
	assign in_y      = s_tdata[piq_pkg::IN_Y_LSB +: piq_pkg::IO_W];
	assign x_ext     = {{16{in_x[piq_pkg::IO_W-1]}}, in_x};
	assign y_ext     = {{16{in_y[piq_pkg::IO_W-1]}}, in_y};
	assign pos_ext   = XW'(in_pos);
	assign cnt_ext   = XW'(count_q);

	// Status toward the controller
	always_comb begin
		sts.action     = in_action;
		sts.pos_bad    = (in_action == piq_pkg::ACT_INSERT) && (pos_ext > cnt_ext);
		sts.full       = (count_q == CW'(DEPTH));
		sts.empty      = (count_q == '0);
		sts.shift_more = (idx_q > pos_q);
		sts.srch_hit   = rvalid_s1 && (rdata_q == {y_q, x_q});
		sts.srch_done  = !rvalid_s1 && (idx_q >= count_q);
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	// Memory port selection
	assign srch_issue = cmd.srch_step && (idx_q < count_q);
	always_comb begin
		rd_en   = cmd.sh_rd || cmd.rem_rd || srch_issue;
		rd_addr = head_q;
		if (cmd.sh_rd) begin
			rd_addr = phys(head_q, idx_q - CW'(1));
		end else if (srch_issue) begin
			rd_addr = phys(head_q, idx_q);
		end
		wr_en   = cmd.sh_wr || cmd.put;
		wr_addr = phys(head_q, cmd.put ? pos_q : idx_q);
		wr_data = cmd.put ? {y_q, x_q} : rdata_q;
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Count, head, walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			head_q     <= '0;
			idx_q      <= '0;
			rvalid_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				idx_q     <= (in_action == piq_pkg::ACT_SEARCH) ? '0 : count_q;
				rvalid_s1 <= 1'b0;
			end
			if (cmd.sh_wr) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.srch_step) begin
				rvalid_s1 <= srch_issue;
				if (srch_issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (cmd.put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.rem_fin) begin
				count_q <= count_q - CW'(1);
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Removed head, sign-extended back to the port width
	assign rx_ext = 32'($signed(rdata_q[COORD_WIDTH-1:0]));
	assign ry_ext = 32'($signed(rdata_q[EW-1:COORD_WIDTH]));

	// Operand and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q        <= (in_action == piq_pkg::ACT_APPEND) ? count_q : pos_ext[CW-1:0];
			x_q          <= x_ext[COORD_WIDTH-1:0];
			y_q          <= y_ext[COORD_WIDTH-1:0];
			res_status_q <= piq_pkg::ST_OK;
			res_found_q  <= 1'b0;
			res_rx_q     <= '0;
			res_ry_q     <= '0;
		end
		if (cmd.set_err) begin
			res_status_q <= cmd.err_code;
		end
		if (cmd.set_found) begin
			res_found_q <= 1'b1;
		end
		if (cmd.rem_fin) begin
			res_rx_q <= rx_ext[piq_pkg::IO_W-1:0];
			res_ry_q <= ry_ext[piq_pkg::IO_W-1:0];
		end
		if (cmd.load_out) begin
			m_tdata_q <= {cnt_ext[piq_pkg::ECNT_W-1:0], res_ry_q, res_rx_q,
				res_found_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ hw/rtl/piq_ctrl.sv @@
// Sequencer for the positional insert queue: decodes each item and steps the datapath.
module piq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  piq_pkg::sts_t sts,
	output piq_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SH_RD   = 8'b0000_0010,
		S_SH_WR   = 8'b0000_0100,
		S_REM_RD  = 8'b0000_1000,
		S_REM_FIN = 8'b0001_0000,
		S_SRCH    = 8'b0010_0000,
		S_RESP    = 8'b0100_0000,
		S_SPARE   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					case (sts.action)
						piq_pkg::ACT_APPEND, piq_pkg::ACT_INSERT: begin
							if (sts.pos_bad) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = piq_pkg::ST_POS;
								state_d      = S_RESP;
							end else if (sts.full) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = piq_pkg::ST_FULL;
								state_d      = S_RESP;
							end else begin
								state_d = S_SH_RD;
							end
						end
						piq_pkg::ACT_REMOVE: begin
							if (sts.empty) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = piq_pkg::ST_EMPTY;
								state_d      = S_RESP;
							end else begin
								state_d = S_REM_RD;
							end
						end
						piq_pkg::ACT_SEARCH: begin
							state_d = S_SRCH;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			// Move one entry toward the tail, or drop the new one in its slot
			S_SH_RD: begin
				if (sts.shift_more) begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SH_WR;
				end else begin
					cmd.put = 1'b1;
					state_d = S_RESP;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SH_RD;
			end
			S_REM_RD: begin
				cmd.rem_rd = 1'b1;
				state_d    = S_REM_FIN;
			end
			S_REM_FIN: begin
				cmd.rem_fin = 1'b1;
				state_d     = S_RESP;
			end
			// Pipelined walk: one read issued and one compare per cycle
			S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_hit) begin
					cmd.set_found = 1'b1;
					state_d       = S_RESP;
				end else if (sts.srch_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/positional_insert_queue_unit.sv @@
// Positional insert queue: top level joining the sequencer and the datapath.
//
// An ordered queue of up to DEPTH (x, y) entries kept in a single-port-style
// circular buffer (one write and one registered read per cycle). Each input
// item appends, inserts in front of a position, removes the head or searches
// for an equal entry, and gives exactly one result item with status, found
// flag, removed entry and the count after the operation. Errors (remove from
// empty, position beyond count, queue full) leave the queue unchanged. One
// item is worked at a time; s_tready is high only while the sequencer is idle.
// Each entry that an insert moves takes one read and one write of the memory,
// and a search walk issues one read per cycle and stops at the first match.
// The result sits in an output register, so the next item is taken while it
// waits.
module positional_insert_queue_unit #(
	parameter int DEPTH       = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// action[1:0], position[6:2], item_x[22:7], item_y[38:23], zero[39]
	input  logic [piq_pkg::TDATA_W-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[1:0], found[2], removed_x[18:3], removed_y[34:19], entry_count[39:35]
	output logic [piq_pkg::TDATA_W-1:0]  m_tdata
);

	piq_pkg::cmd_t cmd;
	piq_pkg::sts_t sts;

	piq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	piq_datapath #(
		.DEPTH       (DEPTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

`ifndef ASSERT_OFF
	// One item at a time: the sequencer leaves idle after every accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	// A failed operation reports no removed entry and no match
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[piq_pkg::OUT_STATUS_LSB +: piq_pkg::STATUS_W] != piq_pkg::ST_OK)
		|-> (m_tdata[piq_pkg::OUT_RY_LSB + piq_pkg::IO_W - 1:piq_pkg::OUT_FOUND_LSB] == '0))
		else $error("error result carries data");

	// A result is only loaded when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result overwrote a pending output item");
`endif

endmodule
